/* sv/bei_pkg.sv */
// shared types and constants for the breakpoint envelope interpolator
// no dependencies
package bei_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_EVAL   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic srch_init;  // start binary search
    logic srch_step;  // apply one compare to lo/hi
    logic rd_mid;     // read memories at mid
    logic rd_k;       // read memories at k
    logic rd_km1;     // read memories at k-1
    logic cap_g;      // capture entry k as upper point
    logic cap_l;      // capture entry k-1 as lower point
    logic diff;       // form sign and magnitude of dy
    logic mul;        // form magnitude product
    logic div_init;   // start division
    logic div_step;   // one restoring division step
    logic shift_rd;   // read entry j-1
    logic shift_wr;   // write entry j from read data, j--
    logic ins_wr;     // write new item at k
    logic upd_wr;     // overwrite value at k
    logic cnt_inc;
    logic cnt_clr;
    logic set_res;    // result from interpolation
    logic set_first;  // result from entry 0 (read data)
    logic set_last;   // result from entry count-1 (read data)
    logic set_zero;
    logic set_full;
    logic rd_first;
    logic rd_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic srch_done;
    logic cnt_zero;
    logic k_zero;
    logic k_end;
    logic full;
    logic match;      // read data time equals request
    logic shift_done; // j == k
    logic div_done;
  } sts_t;

endpackage

/* sv/bei_ram.sv */
// generic single port ram with registered read
// no dependencies
module bei_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* sv/bei_datapath.sv */
// datapath: breakpoint memories, search registers, multiply and divide
// depends on bei_pkg and bei_ram
module bei_datapath #(
  parameter int Entries    = 64,
  parameter int TimeWidth  = 32,
  parameter int ValueWidth = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bei_pkg::cmd_t         cmd_i,
  output bei_pkg::sts_t         sts_o,
  input  logic [1:0]            op_i,
  input  logic [TimeWidth-1:0]  time_i,
  input  logic [ValueWidth-1:0] value_i,
  output logic [ValueWidth-1:0] res_o,
  output logic                  status_o
);
  localparam int AW = $clog2(Entries);
  localparam int CW = $clog2(Entries + 1);
  localparam int DW = ValueWidth + 1;       // dy magnitude width
  localparam int PW = DW + TimeWidth;       // product width
  localparam int NW = $clog2(PW + 1);

  logic [1:0]            op_q;
  logic [TimeWidth-1:0]  t_q;
  logic [ValueWidth-1:0] v_q;
  logic [CW-1:0]         cnt_q, lo_q, hi_q, j_q;
  logic [TimeWidth-1:0]  xg_q, dt_q, dx_q;
  logic [ValueWidth-1:0] yl_q, yg_q;
  logic                  neg_q;
  logic [DW-1:0]         mag_q;
  logic [PW-1:0]         prod_q, quo_q;
  logic [TimeWidth-1:0]  rem_q;
  logic [NW-1:0]         dcnt_q;
  logic [ValueWidth-1:0] res_q;
  logic                  status_q;

  logic [CW-1:0]         mid;
  logic [CW-1:0]         addr_w;
  logic                  we;
  logic [TimeWidth-1:0]  wt, rt;
  logic [ValueWidth-1:0] wv, rv;
  logic [CW-1:0]         jm1;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign jm1 = j_q - CW'(1);

  always_comb begin
    addr_w = mid;
    we     = 1'b0;
    wt     = rt;
    wv     = rv;
    if (cmd_i.rd_k) addr_w = lo_q;
    if (cmd_i.rd_km1) addr_w = lo_q - CW'(1);
    if (cmd_i.rd_first) addr_w = '0;
    if (cmd_i.rd_last) addr_w = cnt_q - CW'(1);
    if (cmd_i.shift_rd) addr_w = jm1;
    if (cmd_i.shift_wr) begin
      addr_w = j_q;
      we     = 1'b1;
    end
    if (cmd_i.ins_wr || cmd_i.upd_wr) begin
      addr_w = lo_q;
      we     = 1'b1;
      wt     = t_q;
      wv     = v_q;
    end
  end

  bei_ram #(.Width(TimeWidth), .Depth(Entries)) u_times (
    .clk_i, .we_i(we), .addr_i(addr_w[AW-1:0]), .wdata_i(wt), .rdata_o(rt)
  );
  bei_ram #(.Width(ValueWidth), .Depth(Entries)) u_values (
    .clk_i, .we_i(we), .addr_i(addr_w[AW-1:0]), .wdata_i(wv), .rdata_o(rv)
  );

  logic signed [ValueWidth:0] dy;
  logic [TimeWidth:0]         rsh;
  logic [TimeWidth:0]         rsub;
  logic signed [ValueWidth:0] resw;

  assign dy   = $signed({yg_q[ValueWidth-1], yg_q}) - $signed({yl_q[ValueWidth-1], yl_q});
  assign rsh  = {rem_q, prod_q[PW-1]};
  assign rsub = rsh - {1'b0, dx_q};
  assign resw = neg_q ? $signed({yl_q[ValueWidth-1], yl_q}) - $signed(quo_q[DW-1:0])
                      : $signed({yl_q[ValueWidth-1], yl_q}) + $signed(quo_q[DW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      res_q    <= '0;
      status_q <= bei_pkg::STATUS_OK;
    end else begin
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.load) begin
        res_q    <= '0;
        status_q <= bei_pkg::STATUS_OK;
      end
      if (cmd_i.set_zero) res_q <= '0;
      if (cmd_i.set_first || cmd_i.set_last) res_q <= rv;
      if (cmd_i.set_res) res_q <= resw[ValueWidth-1:0];
      if (cmd_i.set_full) status_q <= bei_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      t_q  <= time_i;
      v_q  <= value_i;
    end
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= cnt_q;
      j_q  <= cnt_q;
    end
    if (cmd_i.srch_step) begin
      if (rt < t_q) lo_q <= mid + CW'(1);
      else hi_q <= mid;
    end
    if (cmd_i.shift_wr) j_q <= jm1;
    if (cmd_i.cap_g) begin
      xg_q <= rt;
      yg_q <= rv;
    end
    if (cmd_i.cap_l) begin
      yl_q <= rv;
      dt_q <= t_q - rt;
      dx_q <= xg_q - rt;
    end
    if (cmd_i.diff) begin
      neg_q <= dy[ValueWidth];
      mag_q <= dy[ValueWidth] ? DW'(-dy) : DW'(dy);
    end
    if (cmd_i.mul) prod_q <= PW'(mag_q) * PW'(dt_q);
    if (cmd_i.div_init) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= NW'(PW);
    end
    if (cmd_i.div_step) begin
      prod_q <= prod_q << 1;
      dcnt_q <= dcnt_q - NW'(1);
      // remainder stays below dx; the top bit of rsub flags a borrow
      if (!rsub[TimeWidth]) begin
        rem_q <= rsub[TimeWidth-1:0];
        quo_q <= {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_q <= rsh[TimeWidth-1:0];
        quo_q <= {quo_q[PW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.srch_done  = (lo_q == hi_q);
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.k_zero     = (lo_q == '0);
  assign sts_o.k_end      = (lo_q == cnt_q);
  assign sts_o.full       = (cnt_q == CW'(Entries));
  assign sts_o.match      = (rt == t_q);
  assign sts_o.shift_done = (j_q == lo_q);
  assign sts_o.div_done   = (dcnt_q == '0);

  assign res_o    = res_q;
  assign status_o = status_q;
endmodule

/* sv/bei_ctrl.sv */
// controller state machine sequencing search, insert shift and division
// depends on bei_pkg
module bei_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          out_busy_i,
  output logic          in_ready_o,
  output logic          out_load_o,
  output bei_pkg::cmd_t cmd_o,
  input  bei_pkg::sts_t sts_i
);
  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CMP, S_EV_RDK, S_EV_WK,
    S_EV_RDL, S_EV_WL, S_EV_DIFF, S_EV_MUL, S_EV_DINIT, S_EV_DIV, S_EV_RES,
    S_EV_END, S_IN_RDK, S_IN_WK, S_IN_CHK, S_SH_RD, S_SH_WAIT, S_SH_WR,
    S_FIN
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else begin
      case (state_q)
        S_IDLE:    if (in_fire_i) state_q <= S_DISP;
        S_DISP: begin
          case (sts_i.op)
            bei_pkg::OP_INSERT: state_q <= S_SRCH_RD;
            bei_pkg::OP_EVAL: state_q <= sts_i.cnt_zero ? S_FIN : S_SRCH_RD;
            default: state_q <= S_FIN;
          endcase
        end
        S_SRCH_RD:   state_q <= sts_i.srch_done ?
                                (sts_i.op == bei_pkg::OP_EVAL ? S_EV_RDK : S_IN_RDK)
                                : S_SRCH_WAIT;
        S_SRCH_WAIT: state_q <= S_SRCH_CMP;
        S_SRCH_CMP:  state_q <= S_SRCH_RD;
        S_EV_RDK:    state_q <= S_EV_WK;
        S_EV_WK:     state_q <= (sts_i.k_zero || sts_i.k_end) ? S_EV_END : S_EV_RDL;
        S_EV_END:    state_q <= S_FIN;
        S_EV_RDL:    state_q <= S_EV_WL;
        S_EV_WL:     state_q <= S_EV_DIFF;
        S_EV_DIFF:   state_q <= S_EV_MUL;
        S_EV_MUL:    state_q <= S_EV_DINIT;
        S_EV_DINIT:  state_q <= S_EV_DIV;
        S_EV_DIV:    if (sts_i.div_done) state_q <= S_EV_RES;
        S_EV_RES:    state_q <= S_FIN;
        S_IN_RDK:    state_q <= S_IN_WK;
        S_IN_WK:     state_q <= S_IN_CHK;
        S_IN_CHK: begin
          if ((!sts_i.k_end && sts_i.match) || sts_i.full) state_q <= S_FIN;
          else state_q <= sts_i.shift_done ? S_FIN : S_SH_RD;
        end
        S_SH_RD:     state_q <= sts_i.shift_done ? S_FIN : S_SH_WAIT;
        S_SH_WAIT:   state_q <= S_SH_WR;
        S_SH_WR:     state_q <= S_SH_RD;
        S_FIN:       if (!out_busy_i) state_q <= S_IDLE;
        default:     state_q <= S_IDLE;
      endcase
    end
  end

  logic new_ins;
  assign new_ins = !((!sts_i.k_end && sts_i.match) || sts_i.full);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:      cmd_o.load = in_fire_i;
      S_DISP: begin
        cmd_o.srch_init = 1'b1;
        cmd_o.cnt_clr   = (sts_i.op == bei_pkg::OP_CLEAR);
      end
      S_SRCH_RD:   cmd_o.rd_mid = 1'b1;
      S_SRCH_WAIT: cmd_o.rd_mid = 1'b1;
      S_SRCH_CMP:  cmd_o.srch_step = 1'b1;
      S_EV_RDK: begin
        cmd_o.rd_k     = !sts_i.k_zero && !sts_i.k_end;
        cmd_o.rd_first = sts_i.k_zero;
        cmd_o.rd_last  = sts_i.k_end;
      end
      S_EV_WK: begin
        cmd_o.cap_g     = 1'b1;
        cmd_o.set_first = sts_i.k_zero;
        cmd_o.set_last  = sts_i.k_end && !sts_i.k_zero;
      end
      S_EV_RDL:    cmd_o.rd_km1 = 1'b1;
      S_EV_WL:     cmd_o.cap_l = 1'b1;
      S_EV_DIFF:   cmd_o.diff = 1'b1;
      S_EV_MUL:    cmd_o.mul = 1'b1;
      S_EV_DINIT:  cmd_o.div_init = 1'b1;
      S_EV_DIV:    cmd_o.div_step = !sts_i.div_done;
      S_EV_RES:    cmd_o.set_res = 1'b1;
      S_IN_RDK:    cmd_o.rd_k = 1'b1;
      S_IN_CHK: begin
        cmd_o.upd_wr   = !sts_i.k_end && sts_i.match;
        cmd_o.set_full = sts_i.full && !(!sts_i.k_end && sts_i.match);
        cmd_o.ins_wr   = new_ins && sts_i.shift_done;
        cmd_o.cnt_inc  = new_ins && sts_i.shift_done;
      end
      S_SH_RD: begin
        // once the gap at k is open the new item goes in
        cmd_o.shift_rd = !sts_i.shift_done;
        cmd_o.ins_wr   = sts_i.shift_done;
        cmd_o.cnt_inc  = sts_i.shift_done;
      end
      S_SH_WAIT:   cmd_o.shift_rd = 1'b1;
      S_SH_WR:     cmd_o.shift_wr = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load_o = (state_q == S_FIN) && !out_busy_i;
endmodule

/* sv/breakpoint_envelope_interpolator.sv */
// breakpoint envelope interpolator, top level
// clear, no-op and empty evaluate end at dispatch; insert and evaluate run a binary
// search of s steps (up to log2(n)+1) over the single memory port; insert updates a
// matching entry or, if not full, shifts entries up and writes the new item; evaluate
// at the ends returns that entry, inside it interpolates in PW divider steps, with
// PW = VALUE_WIDTH+1+TIME_WIDTH (57); one item at a time, ready again the cycle after
// the result loads; a result held in the output register stalls the next item at its
// end; reset (rst_ni low, async) empties the table, memory contents stay undefined
module breakpoint_envelope_interpolator #(
  parameter int ENTRIES     = 64,
  parameter int TIME_WIDTH  = 32,
  parameter int VALUE_WIDTH = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tuser: operation[1:0]
  input  logic [1:0] s_axis_tuser,
  // tdata: time_req, value, zero pad
  input  logic [((TIME_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tuser: status
  output logic m_axis_tuser,
  // tdata: result_value, zero pad
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  localparam int OW = ((VALUE_WIDTH+7)/8)*8;

  bei_pkg::cmd_t cmd;
  bei_pkg::sts_t sts;
  logic          in_fire, out_load;
  logic [VALUE_WIDTH-1:0] res;
  logic          status;
  logic          ov_q;
  logic [VALUE_WIDTH-1:0] od_q;
  logic          os_q;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  bei_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_busy_i(ov_q && !m_axis_tready),
    .in_ready_o(s_axis_tready), .out_load_o(out_load), .cmd_o(cmd), .sts_i(sts)
  );

  bei_datapath #(
    .Entries(ENTRIES), .TimeWidth(TIME_WIDTH), .ValueWidth(VALUE_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .op_i(s_axis_tuser),
    .time_i(s_axis_tdata[TIME_WIDTH-1:0]),
    .value_i(s_axis_tdata[TIME_WIDTH+VALUE_WIDTH-1:TIME_WIDTH]),
    .res_o(res), .status_o(status)
  );

  // output register, holds a result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (out_load) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      od_q <= res;
      os_q <= status;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = os_q;
  assign m_axis_tdata  = OW'(od_q);
endmodule
